@@ hw/rtl/pscp_pkg.sv @@
package pscp_pkg;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int DOT_W      = PROD_W + 2;
    localparam int T_W        = 17;
    localparam int DIST_W     = 63;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_CFG    = 6;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X = 3'd0,
        CFG_START_Y = 3'd1,
        CFG_START_Z = 3'd2,
        CFG_END_X   = 3'd3,
        CFG_END_Y   = 3'd4,
        CFG_END_Z   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] query_z;
        logic signed [COORD_W-1:0] query_y;
        logic signed [COORD_W-1:0] query_x;
    } query_t;

    typedef struct packed {
        logic                      degenerate;
        logic [DIST_W-1:0]         dist_sq;
        logic signed [COORD_W-1:0] near_z;
        logic signed [COORD_W-1:0] near_y;
        logic signed [COORD_W-1:0] near_x;
        logic [T_W-1:0]            param_t;
    } result_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vec_t;

    typedef enum logic [1:0] {
        SEL_START  = 2'd0,
        SEL_END    = 2'd1,
        SEL_INSIDE = 2'd2
    } sel_t;

endpackage

@@ hw/rtl/point_segment_closest_point.sv @@
// Closest point on a 3D segment. The user must write the segment start and end through
// the cfg port only while the block is idle; the block does not enforce this. Each
// query item (signed Q16.16 point) yields one item with the clamped parameter t, the
// closest point, the saturated squared distance and a degenerate flag. The pipeline
// takes one item per cycle unless the output stalls; its depth is set by the restoring
// divider (one quotient bit per stage) and the registered dot-product and distance
// multipliers. A stalled output holds the whole pipeline.
module point_segment_closest_point #(
    parameter int FRAC_BITS = pscp_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [pscp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pscp_pkg::COORD_W-1:0]     cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  pscp_pkg::query_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output pscp_pkg::result_t                m_data
);
    import pscp_pkg::*;

    localparam int QW  = T_W + 8;
    localparam int NS  = FRAC_BITS + 7;

    typedef struct packed {
        logic signed [COORD_W-1:0] qx, qy, qz;
        logic signed [DIFF_W-1:0]  mx, my, mz;
    } item_t;

    vec_t start_reg, end_reg;
    logic adv;
    logic [NS-1:0] v_reg;
    assign adv     = m_ready || !m_valid;
    assign s_ready = adv;
    assign m_valid = v_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            end_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_START_X: start_reg.x <= cfg_data;
                CFG_START_Y: start_reg.y <= cfg_data;
                CFG_START_Z: start_reg.z <= cfg_data;
                CFG_END_X:   end_reg.x   <= cfg_data;
                CFG_END_Y:   end_reg.y   <= cfg_data;
                CFG_END_Z:   end_reg.z   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg <= '0;
        else if (adv) v_reg <= {v_reg[NS-2:0], s_valid};
    end

    // stage 0: differences
    item_t it0_reg;
    logic signed [DIFF_W-1:0] dx0_reg, dy0_reg, dz0_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            it0_reg.qx <= s_data.query_x;
            it0_reg.qy <= s_data.query_y;
            it0_reg.qz <= s_data.query_z;
            it0_reg.mx <= DIFF_W'(end_reg.x) - DIFF_W'(start_reg.x);
            it0_reg.my <= DIFF_W'(end_reg.y) - DIFF_W'(start_reg.y);
            it0_reg.mz <= DIFF_W'(end_reg.z) - DIFF_W'(start_reg.z);
            dx0_reg <= DIFF_W'(s_data.query_x) - DIFF_W'(start_reg.x);
            dy0_reg <= DIFF_W'(s_data.query_y) - DIFF_W'(start_reg.y);
            dz0_reg <= DIFF_W'(s_data.query_z) - DIFF_W'(start_reg.z);
        end
    end

    // stage 1: products
    item_t it1_reg;
    logic signed [PROD_W-1:0] n0_reg, n1_reg, n2_reg, d0_reg, d1_reg, d2_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            it1_reg <= it0_reg;
            n0_reg <= it0_reg.mx * dx0_reg;
            n1_reg <= it0_reg.my * dy0_reg;
            n2_reg <= it0_reg.mz * dz0_reg;
            d0_reg <= it0_reg.mx * it0_reg.mx;
            d1_reg <= it0_reg.my * it0_reg.my;
            d2_reg <= it0_reg.mz * it0_reg.mz;
        end
    end

    // stage 2: dot sums and classification
    item_t it2_reg;
    sel_t  sel2_reg;
    logic  deg2_reg;
    logic [DOT_W-1:0] num2_reg, den2_reg;
    logic signed [DOT_W-1:0] num_s, den_s;
    always_comb begin
        num_s = DOT_W'(n0_reg) + DOT_W'(n1_reg) + DOT_W'(n2_reg);
        den_s = DOT_W'(d0_reg) + DOT_W'(d1_reg) + DOT_W'(d2_reg);
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            it2_reg  <= it1_reg;
            num2_reg <= num_s;
            den2_reg <= den_s;
            deg2_reg <= (den_s == '0);
            if (den_s == '0 || num_s[DOT_W-1] || num_s == '0) sel2_reg <= SEL_START;
            else if (num_s >= den_s) sel2_reg <= SEL_END;
            else sel2_reg <= SEL_INSIDE;
        end
    end

    // divider stages
    item_t            itd_reg  [FRAC_BITS];
    sel_t             seld_reg [FRAC_BITS];
    logic             degd_reg [FRAC_BITS];
    logic [DOT_W-1:0] remd_reg [FRAC_BITS];
    logic [DOT_W-1:0] dend_reg [FRAC_BITS];
    logic [QW-1:0]    qd_reg   [FRAC_BITS];

    for (genvar g = 0; g < FRAC_BITS; g++) begin : g_div
        item_t            it_in;
        sel_t             sel_in;
        logic             deg_in;
        logic [DOT_W-1:0] rem_in, den_in, rem_nx;
        logic [QW-1:0]    q_in, q_nx;
        if (g == 0) begin : g_first
            assign it_in  = it2_reg;
            assign sel_in = sel2_reg;
            assign deg_in = deg2_reg;
            assign rem_in = num2_reg;
            assign den_in = den2_reg;
            assign q_in   = '0;
        end else begin : g_next
            assign it_in  = itd_reg[g-1];
            assign sel_in = seld_reg[g-1];
            assign deg_in = degd_reg[g-1];
            assign rem_in = remd_reg[g-1];
            assign den_in = dend_reg[g-1];
            assign q_in   = qd_reg[g-1];
        end
        pscp_div_step u_step (
            .rem_in (rem_in),
            .den    (den_in),
            .q_in   (q_in),
            .rem_out(rem_nx),
            .q_out  (q_nx)
        );
        always_ff @(posedge aclk) begin
            if (adv) begin
                itd_reg[g]  <= it_in;
                seld_reg[g] <= sel_in;
                degd_reg[g] <= deg_in;
                dend_reg[g] <= den_in;
                remd_reg[g] <= rem_nx;
                qd_reg[g]   <= q_nx;
            end
        end
    end

    // t select and m*t product
    item_t it4_reg;
    sel_t  sel4_reg;
    logic  deg4_reg;
    logic [QW-1:0] t4_reg;
    logic signed [DIFF_W+QW:0] px4_reg, py4_reg, pz4_reg;
    logic [QW-1:0] t_sel;
    always_comb begin
        case (seld_reg[FRAC_BITS-1])
            SEL_START:  t_sel = '0;
            SEL_END:    t_sel = QW'(1) << FRAC_BITS;
            SEL_INSIDE: t_sel = qd_reg[FRAC_BITS-1];
            default:    t_sel = '0;
        endcase
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            it4_reg  <= itd_reg[FRAC_BITS-1];
            sel4_reg <= seld_reg[FRAC_BITS-1];
            deg4_reg <= degd_reg[FRAC_BITS-1];
            t4_reg   <= t_sel;
            px4_reg  <= itd_reg[FRAC_BITS-1].mx * $signed({1'b0, t_sel});
            py4_reg  <= itd_reg[FRAC_BITS-1].my * $signed({1'b0, t_sel});
            pz4_reg  <= itd_reg[FRAC_BITS-1].mz * $signed({1'b0, t_sel});
        end
    end

    // near point and query difference
    logic signed [COORD_W-1:0] nx, ny, nz;
    logic signed [COORD_W-1:0] sx, sy, sz;
    always_comb begin
        sx = start_reg.x; sy = start_reg.y; sz = start_reg.z;
        case (sel4_reg)
            SEL_END: begin
                nx = end_reg.x; ny = end_reg.y; nz = end_reg.z;
            end
            SEL_INSIDE: begin
                nx = sx + COORD_W'(px4_reg >>> FRAC_BITS);
                ny = sy + COORD_W'(py4_reg >>> FRAC_BITS);
                nz = sz + COORD_W'(pz4_reg >>> FRAC_BITS);
            end
            default: begin
                nx = sx; ny = sy; nz = sz;
            end
        endcase
    end

    result_t r5_reg;
    logic signed [DIFF_W:0] dx5_reg, dy5_reg, dz5_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            r5_reg.param_t    <= T_W'(t4_reg);
            r5_reg.near_x     <= nx;
            r5_reg.near_y     <= ny;
            r5_reg.near_z     <= nz;
            r5_reg.degenerate <= deg4_reg;
            r5_reg.dist_sq    <= '0;
            dx5_reg <= (DIFF_W+1)'(it4_reg.qx) - (DIFF_W+1)'(nx);
            dy5_reg <= (DIFF_W+1)'(it4_reg.qy) - (DIFF_W+1)'(ny);
            dz5_reg <= (DIFF_W+1)'(it4_reg.qz) - (DIFF_W+1)'(nz);
        end
    end

    // squared distance
    result_t r6_reg;
    logic [DOT_W+1:0] ssq;
    pscp_dist u_dist (
        .aclk  (aclk),
        .en    (adv),
        .dx    (dx5_reg),
        .dy    (dy5_reg),
        .dz    (dz5_reg),
        .sum_sq(ssq)
    );
    always_ff @(posedge aclk) begin
        if (adv) r6_reg <= r5_reg;
    end

    logic [DOT_W+1:0] ssh;
    result_t r7_reg;
    result_t r7_next;
    always_comb ssh = ssq >> FRAC_BITS;
    always_comb begin
        r7_next = r6_reg;
        if (|ssh[DOT_W+1:DIST_W]) r7_next.dist_sq = '1;
        else r7_next.dist_sq = ssh[DIST_W-1:0];
    end
    always_ff @(posedge aclk) begin
        if (adv) r7_reg <= r7_next;
    end
    assign m_data = r7_reg;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    a_t_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.param_t <= T_W'(1 << FRAC_BITS))
        else $error("param_t above one");
    a_degen_t: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |-> m_data.param_t == '0)
        else $error("degenerate item with nonzero t");
endmodule

@@ hw/rtl/pscp_div_step.sv @@
module pscp_div_step (
    input  logic [pscp_pkg::DOT_W-1:0] rem_in,
    input  logic [pscp_pkg::DOT_W-1:0] den,
    input  logic [pscp_pkg::T_W+8-1:0] q_in,
    output logic [pscp_pkg::DOT_W-1:0] rem_out,
    output logic [pscp_pkg::T_W+8-1:0] q_out
);
    import pscp_pkg::*;
    logic [DOT_W:0] sh;
    logic [DOT_W:0] diff;
    always_comb begin
        sh   = {rem_in, 1'b0};
        diff = sh - {1'b0, den};
        if (!diff[DOT_W]) begin
            rem_out = diff[DOT_W-1:0];
            q_out   = {q_in[T_W+8-2:0], 1'b1};
        end else begin
            rem_out = sh[DOT_W-1:0];
            q_out   = {q_in[T_W+8-2:0], 1'b0};
        end
    end
endmodule

@@ hw/rtl/pscp_dist.sv @@
module pscp_dist (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [pscp_pkg::DIFF_W:0]  dx,
    input  logic signed [pscp_pkg::DIFF_W:0]  dy,
    input  logic signed [pscp_pkg::DIFF_W:0]  dz,
    output logic [pscp_pkg::DOT_W+1:0]        sum_sq
);
    import pscp_pkg::*;
    logic [2*DIFF_W+1:0] px_reg, py_reg, pz_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= (2*DIFF_W+2)'(dx * dx);
            py_reg <= (2*DIFF_W+2)'(dy * dy);
            pz_reg <= (2*DIFF_W+2)'(dz * dz);
        end
    end
    assign sum_sq = (DOT_W+2)'(px_reg) + (DOT_W+2)'(py_reg) + (DOT_W+2)'(pz_reg);
endmodule
